// ===== sv/parallel_beam_backprojection_core_defines.svh =====
// Assertion macros shared by the checker
`ifndef PARALLEL_BEAM_BACKPROJECTION_CORE_DEFINES_SVH
`define PARALLEL_BEAM_BACKPROJECTION_CORE_DEFINES_SVH

// Same-cycle implication
`define BPJ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bpj check failed");

// Next-cycle implication
`define BPJ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bpj check failed");

`endif

// ===== sv/bpj_pkg.sv =====
package bpj_pkg;

    localparam int IMAGE_SIZE_DEF = 64;
    localparam int NUM_ANGLES_DEF = 64;

    // Q1.16 trig word and pi in Q30
    localparam int TRIG_W = 18;
    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam longint unsigned ONE_Q30 = 64'd1073741824;

    typedef struct packed {
        logic signed [TRIG_W-1:0] cos_v;
        logic signed [TRIG_W-1:0] sin_v;
    } trig_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_SCALE,
        ST_FINISH
    } state_t;

    // Unsigned quotient by shift and subtract, used only while building the trig cell reset values
    function automatic longint unsigned div_u64(longint unsigned n, longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = (r << 1) | ((n >> b) & 64'd1);
            q = q << 1;
            if (r >= d) begin
                r = r - d;
                q = q | 64'd1;
            end
        end
        return q;
    endfunction

    // Taylor series for sine, Q30, argument in 0..pi/2
    function automatic longint sin_q30(longint unsigned x);
        longint unsigned x2;
        longint unsigned term;
        longint sum;
        x2 = (x * x) >> 30;
        term = x;
        sum = longint'(term);
        for (int i = 0; i < 12; i++) begin
            term = (term * x2) >> 30;
            term = div_u64(term, longint'(2 * i + 2) * longint'(2 * i + 3));
            if ((i % 2) == 1) sum = sum + longint'(term);
            else sum = sum - longint'(term);
        end
        return sum;
    endfunction

    // Taylor series for cosine, Q30, argument in 0..pi/2
    function automatic longint cos_q30(longint unsigned x);
        longint unsigned x2;
        longint unsigned term;
        longint sum;
        x2 = (x * x) >> 30;
        term = ONE_Q30;
        sum = longint'(term);
        for (int i = 0; i < 12; i++) begin
            term = (term * x2) >> 30;
            term = div_u64(term, longint'(2 * i + 1) * longint'(2 * i + 2));
            if ((i % 2) == 1) sum = sum + longint'(term);
            else sum = sum - longint'(term);
        end
        return sum;
    endfunction

    // Round Q30 to Q16, half away from zero
    function automatic logic signed [TRIG_W-1:0] q30_to_q16(longint v);
        longint m;
        if (v < 0) begin
            m = (-v + 8192) >>> 14;
            return TRIG_W'(-m);
        end
        m = (v + 8192) >>> 14;
        return TRIG_W'(m);
    endfunction

endpackage

// ===== sv/bpj_cell.sv =====
module bpj_cell #(
    parameter bpj_pkg::trig_t INIT = '0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           shift,
    input  bpj_pkg::trig_t trig_in,
    output bpj_pkg::trig_t trig_out
);
    import bpj_pkg::*;

    trig_t trig_reg;

    // Load own angle at reset, pass to neighbour on shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_reg <= INIT;
        end
        else if (shift)
        begin
            trig_reg <= trig_in;
        end
    end

    assign trig_out = trig_reg;

endmodule

// ===== sv/bpj_store.sv =====
module bpj_store #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic        clk,
    input  logic        en,
    input  logic        we,
    input  logic [AW-1:0] addr,
    input  logic signed [23:0] wdata,
    output logic signed [23:0] rdata
);
    logic signed [23:0] mem [DEPTH];

    // Single port: write or registered read
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

// ===== sv/parallel_beam_backprojection_core.sv =====
// Channel   | Signals                                             | Transfer
// ----------+-----------------------------------------------------+--------------------
// command   | op scan_index angle_index sample_value pixel_x/y    | start & !busy
// result    | pixel_value inside_circle                           | done (one cycle)
//
// A load in range writes the store when it is accepted. A pixel inside the
// circle makes at most one store read per angle from the single-port
// sinogram store, then goes through pipeline drain, scale and output. A
// pixel outside the circle returns its zero result in the next cycle. rst_n
// clears control asynchronously; the store is undefined until written.
// Results are never stalled; done is high for one cycle per result.
module parallel_beam_backprojection_core #(
    parameter int IMAGE_SIZE = bpj_pkg::IMAGE_SIZE_DEF,
    parameter int NUM_ANGLES = bpj_pkg::NUM_ANGLES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               op,
    input  logic [5:0]         scan_index,
    input  logic [5:0]         angle_index,
    input  logic signed [23:0] sample_value,
    input  logic [5:0]         pixel_x,
    input  logic [5:0]         pixel_y,
    output logic               done,
    output logic signed [31:0] pixel_value,
    output logic               inside_circle
);
    import bpj_pkg::*;

    localparam int DEPTH = IMAGE_SIZE * NUM_ANGLES;
    localparam int AW    = $clog2(DEPTH);
    localparam int KW    = (NUM_ANGLES > 1) ? $clog2(NUM_ANGLES) : 1;
    localparam int SPAN  = IMAGE_SIZE - 1;
    localparam int TW    = 29;
    localparam int NW    = TW - 17;
    localparam longint STEP = longint'((PI_Q30 + longint'(NUM_ANGLES) * 8192) /
                                       (longint'(NUM_ANGLES) * 16384));
    localparam int SW    = 19;
    localparam int PW    = 33 + SW;

    // Ring of trig cells
    trig_t ring [NUM_ANGLES];
    logic  shift;

    for (genvar g = 0; g < NUM_ANGLES; g++)
    begin : g_cell
        localparam bit MIRROR = (2 * g > NUM_ANGLES);
        localparam longint unsigned KK = MIRROR ? longint'(NUM_ANGLES - g) : longint'(g);
        localparam longint unsigned XA = (KK * PI_Q30) / NUM_ANGLES;
        localparam logic signed [TRIG_W-1:0] CV = q30_to_q16(cos_q30(XA));
        localparam logic signed [TRIG_W-1:0] SV = q30_to_q16(sin_q30(XA));
        localparam trig_t INIT = '{cos_v: (MIRROR ? -CV : CV), sin_v: SV};
        localparam int NEXT = (g == NUM_ANGLES - 1) ? 0 : g + 1;

        bpj_cell #(.INIT(INIT)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift    (shift),
            .trig_in  (ring[NEXT]),
            .trig_out (ring[g])
        );
    end

    state_t state_reg, state_next;
    logic [KW:0] cnt_reg, cnt_next;
    logic        v1_reg, v2_reg, done_reg;
    logic [KW-1:0] k1_reg;
    logic signed [9:0]  xd_reg, yd_reg;
    logic signed [TW-1:0] t_reg;
    logic signed [32:0] sum_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [31:0] value_reg;
    logic        inside_reg;

    // Accept and circle test
    logic accept, pix_req, load_req, in_range_ld, inside_now;
    logic signed [9:0] xd_now, yd_now;
    logic [18:0] dsq;

    assign accept   = start && !busy;
    assign pix_req  = accept && op;
    assign load_req = accept && !op;
    assign in_range_ld = (int'(scan_index) < IMAGE_SIZE) && (int'(angle_index) < NUM_ANGLES);
    assign xd_now = signed'(10'({pixel_x, 1'b0})) - 10'(SPAN);
    assign yd_now = signed'(10'({pixel_y, 1'b0})) - 10'(SPAN);
    assign dsq = 19'(unsigned'(20'(xd_now * xd_now))) + 19'(unsigned'(20'(yd_now * yd_now)));
    assign inside_now = (int'(pixel_x) < IMAGE_SIZE) && (int'(pixel_y) < IMAGE_SIZE) &&
                        (dsq < 19'(SPAN * SPAN));

    // FSM register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state and sequencing outputs
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        shift      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (pix_req && inside_now) state_next = ST_RUN;
            end
            ST_RUN:
            begin
                shift    = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == (KW+1)'(NUM_ANGLES - 1))
                begin
                    state_next = ST_DRAIN;
                    cnt_next   = '0;
                end
            end
            ST_DRAIN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == (KW+1)'(1)) state_next = ST_SCALE;
            end
            ST_SCALE:  state_next = ST_FINISH;
            ST_FINISH: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    // Bin from stage 1 result
    logic signed [TW-1:0] t_next, t_bias;
    logic signed [NW-1:0] n_s;
    logic bin_ok;
    trig_t head;

    assign head   = ring[0];
    assign t_next = TW'(SPAN * 65536) + TW'(xd_reg * head.cos_v) - TW'(yd_reg * head.sin_v);
    assign t_bias = t_reg + TW'(65536);
    assign n_s    = NW'(t_bias >>> 17);
    assign bin_ok = !n_s[NW-1] && (int'(n_s) < IMAGE_SIZE);

    // Store port
    logic st_en, st_we;
    logic [AW-1:0] st_addr;
    logic signed [23:0] st_rdata;

    always_comb
    begin
        st_en   = 1'b0;
        st_we   = 1'b0;
        st_addr = AW'(int'(scan_index) * NUM_ANGLES + int'(angle_index));
        if (load_req && in_range_ld)
        begin
            st_en = 1'b1;
            st_we = 1'b1;
        end
        else if (v1_reg && bin_ok)
        begin
            st_en   = 1'b1;
            st_addr = AW'(int'(n_s) * NUM_ANGLES + int'(k1_reg));
        end
    end

    bpj_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
        .clk   (clk),
        .en    (st_en),
        .we    (st_we),
        .addr  (st_addr),
        .wdata (sample_value),
        .rdata (st_rdata)
    );

    // Pipeline valids and strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= (state_reg == ST_RUN);
            v2_reg   <= v1_reg && bin_ok;
            done_reg <= (state_reg == ST_FINISH) || (pix_req && !inside_now);
        end
    end

    // Round and saturate the scaled sum
    logic signed [PW-1:0] rnd;
    logic signed [PW-17:0] res;
    logic signed [31:0] sat;

    assign rnd = prod_reg + PW'(32768);
    assign res = (PW-16)'(rnd >>> 16);
    always_comb
    begin
        if (res > (PW-16)'(32'sh7FFFFFFF)) sat = 32'sh7FFFFFFF;
        else if (res < -(PW-16)'(33'sh080000000)) sat = 32'sh80000000;
        else sat = 32'(res);
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (pix_req)
        begin
            xd_reg  <= xd_now;
            yd_reg  <= yd_now;
            sum_reg <= '0;
        end
        else if (v2_reg)
        begin
            sum_reg <= sum_reg + 33'(st_rdata);
        end
        t_reg  <= t_next;
        k1_reg <= cnt_reg[KW-1:0];
        if (state_reg == ST_SCALE)
        begin
            prod_reg <= PW'(sum_reg) * PW'(signed'({1'b0, (SW-1)'(STEP)}));
        end
        if (state_reg == ST_FINISH)
        begin
            value_reg  <= sat;
            inside_reg <= 1'b1;
        end
        else if (pix_req && !inside_now)
        begin
            value_reg  <= '0;
            inside_reg <= 1'b0;
        end
    end

    assign done          = done_reg;
    assign pixel_value   = value_reg;
    assign inside_circle = inside_reg;

endmodule

// ===== sv/bpj_checker.sv =====
module bpj_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               op,
    input logic               done,
    input logic signed [31:0] pixel_value,
    input logic               inside_circle
);
`include "parallel_beam_backprojection_core_defines.svh"

    // Outside pixels carry zero
    `BPJ_ASSERT_NOW(a_outside_zero, clk, rst_n, done && !inside_circle, pixel_value == 32'sd0)
    // Result is only shown when idle
    `BPJ_ASSERT_NOW(a_done_idle, clk, rst_n, done, !busy)
    // A load transfer yields no result
    `BPJ_ASSERT_NEXT(a_load_silent, clk, rst_n, start && !busy && !op, !done)
    // A pixel transfer starts work or answers at once
    `BPJ_ASSERT_NEXT(a_pixel_moves, clk, rst_n, start && !busy && op, busy || done)

endmodule

bind parallel_beam_backprojection_core bpj_checker u_bpj_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .op            (op),
    .done          (done),
    .pixel_value   (pixel_value),
    .inside_circle (inside_circle)
);

// ===== verif/tb_parallel_beam_backprojection_core.sv =====
`timescale 1ns / 100ps

module tb_parallel_beam_backprojection_core;

    localparam int SIZE   = 64;
    localparam int ANGLES = 64;
    localparam int DEPTH  = SIZE * ANGLES;

    typedef enum bit {OP_LOAD = 1'b0, OP_PIXEL = 1'b1} cmd_op_t;

    typedef struct {
        logic signed [31:0] value;
        logic               in_circle;
    } pixel_result_t;

    // Backprojection predictor: sinogram copy, trig table, expected pixels
    class backprojection_scoreboard;
        logic signed [23:0] sinogram [DEPTH];
        longint             cos_tab [ANGLES];
        longint             sin_tab [ANGLES];
        longint             scale_q16;
        pixel_result_t      pending_pixels [$];
        int                 fail_count;

        function new();
            longint unsigned pi_q30;
            longint unsigned arg;
            int              kk;
            bit              mirror;
            pi_q30 = 64'd3373259426;
            fail_count = 0;
            for (int k = 0; k < ANGLES; k++)
            begin
                mirror = (2 * k > ANGLES);
                kk = mirror ? ANGLES - k : k;
                arg = (longint'(kk) * pi_q30) / ANGLES;
                sin_tab[k] = to_q16(taylor(arg, arg, 1));
                cos_tab[k] = to_q16(taylor(arg, 64'd1073741824, 0));
                if (mirror)
                    cos_tab[k] = -cos_tab[k];
            end
            scale_q16 = (pi_q30 + ANGLES * 8192) / (ANGLES * 16384);
        endfunction

        // Alternating series in Q30, argument within a quarter turn
        function longint taylor(longint unsigned x, longint unsigned first, int n0);
            longint unsigned x2;
            longint unsigned term;
            longint          acc;
            int              n;
            x2 = (x * x) >> 30;
            term = first;
            acc = longint'(term);
            n = n0;
            for (int i = 0; i < 12; i++)
            begin
                term = (term * x2) >> 30;
                term = term / (longint'(n + 1) * longint'(n + 2));
                n += 2;
                if (i % 2 == 1)
                    acc += longint'(term);
                else
                    acc -= longint'(term);
            end
            return acc;
        endfunction

        // Round Q30 to Q16, half away from zero
        function longint to_q16(longint v);
            if (v < 0)
                return -((-v + 8192) >>> 14);
            return (v + 8192) >>> 14;
        endfunction

        // Note an accepted command transfer
        function void note_command(cmd_op_t op, int scan, int ang, logic signed [23:0] smp,
                                   int px, int py);
            longint        span, dx, dy, t, bin, acc, res;
            pixel_result_t r;
            if (op == OP_LOAD)
            begin
                if (scan < SIZE && ang < ANGLES)
                    sinogram[scan * ANGLES + ang] = smp;
                return;
            end
            span = SIZE - 1;
            dx = 2 * px - span;
            dy = 2 * py - span;
            r.value = 0;
            r.in_circle = 1'b0;
            if (px < SIZE && py < SIZE && dx * dx + dy * dy < span * span)
            begin
                acc = 0;
                for (int k = 0; k < ANGLES; k++)
                begin
                    t = span * 65536 + dx * cos_tab[k] - dy * sin_tab[k];
                    bin = (t + 65536) >>> 17;
                    if (bin >= 0 && bin < SIZE)
                        acc += longint'(sinogram[bin * ANGLES + k]);
                end
                res = (acc * scale_q16 + 32768) >>> 16;
                if (res > 64'sd2147483647)
                    res = 64'sd2147483647;
                if (res < -64'sd2147483648)
                    res = -64'sd2147483648;
                r.value = res[31:0];
                r.in_circle = 1'b1;
            end
            pending_pixels.push_back(r);
        endfunction

        // Check one result transfer against the oldest expectation
        function void check_result(logic signed [31:0] value, logic in_circle);
            pixel_result_t r;
            if (pending_pixels.size() == 0)
            begin
                $error("unexpected result: pixel_value %0d inside_circle %0b", value, in_circle);
                fail_count++;
                return;
            end
            r = pending_pixels.pop_front();
            if (value !== r.value)
            begin
                $error("pixel_value: expected %0d, actual %0d", r.value, value);
                fail_count++;
            end
            if (in_circle !== r.in_circle)
            begin
                $error("inside_circle: expected %0b, actual %0b", r.in_circle, in_circle);
                fail_count++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               op;
    logic [5:0]         scan_index;
    logic [5:0]         angle_index;
    logic signed [23:0] sample_value;
    logic [5:0]         pixel_x;
    logic [5:0]         pixel_y;
    logic               done;
    logic signed [31:0] pixel_value;
    logic               inside_circle;

    backprojection_scoreboard sb;

    parallel_beam_backprojection_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .scan_index   (scan_index),
        .angle_index  (angle_index),
        .sample_value (sample_value),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .done         (done),
        .pixel_value  (pixel_value),
        .inside_circle(inside_circle)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Check every result transfer
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(pixel_value, inside_circle);
    end

    // Mostly short gaps, now and then a long one, often none
    function automatic int pick_gap();
        int p;
        p = $urandom_range(99);
        if (p < 50)
            return 0;
        if (p < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Drive one command and hold it until the transfer
    task automatic issue(cmd_op_t cmd, int scan, int ang, logic signed [23:0] smp,
                         int px, int py, int gap);
        bit taken;
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        op = cmd;
        scan_index = 6'(scan);
        angle_index = 6'(ang);
        sample_value = smp;
        pixel_x = 6'(px);
        pixel_y = 6'(py);
        start = 1'b1;
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            if (!busy)
            begin
                taken = 1'b1;
                sb.note_command(cmd, scan, ang, smp, px, py);
            end
        end
        @(negedge clk);
    endtask

    task automatic load(int scan, int ang, logic signed [23:0] smp);
        issue(OP_LOAD, scan, ang, smp, $urandom_range(63), $urandom_range(63), pick_gap());
    endtask

    task automatic request(int px, int py);
        issue(OP_PIXEL, $urandom_range(63), $urandom_range(63), 24'($urandom()), px, py,
              pick_gap());
    endtask

    function automatic logic signed [23:0] pick_sample();
        int p;
        p = $urandom_range(19);
        if (p == 0)
            return 24'sh7fffff;
        if (p == 1)
            return -24'sh800000;
        if (p == 2)
            return 24'sd0;
        return 24'($urandom());
    endfunction

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        start = 1'b0;
        op = OP_LOAD;
        scan_index = '0;
        angle_index = '0;
        sample_value = '0;
        pixel_x = '0;
        pixel_y = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Fill the whole sinogram so no request reads an unwritten entry
        for (int a = 0; a < DEPTH; a++)
            issue(OP_LOAD, a / ANGLES, a % ANGLES, pick_sample(), 0, 0, 0);

        // Directed: extreme samples, corners, centre, circle edge
        load(0, 0, 24'sh7fffff);
        load(63, 63, -24'sh800000);
        load(31, 0, 24'sh7fffff);
        load(32, 32, -24'sh800000);
        request(0, 0);
        request(63, 63);
        request(0, 63);
        request(63, 0);
        request(31, 31);
        request(32, 32);
        request(31, 32);
        request(0, 31);
        request(63, 32);
        request(31, 0);
        request(32, 63);
        request(1, 20);
        request(62, 43);
        // Whole column set high, to push the sum toward its maximum
        for (int s = 0; s < SIZE; s++)
            issue(OP_LOAD, s, 5, 24'sh7fffff, 0, 0, 0);
        request(31, 31);
        request(10, 40);

        // Random mix of loads and pixel requests
        for (int n = 0; n < 1200; n++)
        begin
            if ($urandom_range(99) < 60)
                load($urandom_range(63), $urandom_range(63), pick_sample());
            else
                request($urandom_range(63), $urandom_range(63));
        end
        start = 1'b0;

        // Drain outstanding results, then allow for stray ones
        while (sb.pending_pixels.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.fail_count == 0)
            $display("[parallel_beam_backprojection_core] OK");
        else
            $display("[parallel_beam_backprojection_core] ERROR");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("[parallel_beam_backprojection_core] ERROR");
        $finish;
    end

endmodule

// ===== parallel_beam_backprojection_core.f =====
+incdir+sv
sv/bpj_pkg.sv
sv/bpj_cell.sv
sv/bpj_store.sv
sv/parallel_beam_backprojection_core.sv
sv/bpj_checker.sv
verif/tb_parallel_beam_backprojection_core.sv
